>>> src/mtrr_pkg.sv
// mtrr_pkg: shared types, constants and word functions for the mt19937 ranged generator
// no dependencies; imported by mtrr_chain, mtrr_mod and mersenne_twister_ranged_rng_top

package mtrr_pkg;

  localparam int WORD_W           = 32;
  localparam int STATE_WORDS_DEF  = 624;
  localparam int TWIST_OFFSET_DEF = 397;

  localparam logic [WORD_W-1:0] SEED_RESET   = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

  // request beat
  typedef struct packed {
    logic [WORD_W-1:0] range_low;
    logic [WORD_W-1:0] range_high;
  } mtrr_in_t;

  // result beat
  typedef struct packed {
    logic [WORD_W-1:0] random_word;
    logic [WORD_W-1:0] ranged_value;
  } mtrr_out_t;

  // remainder unit status toward the control logic
  typedef struct packed {
    logic busy;
    logic done;
  } mtrr_div_stat_t;

  // one twist step from the head word, its successor and the far tap
  function automatic logic [WORD_W-1:0] mt_twist(input logic [WORD_W-1:0] head,
                                                 input logic [WORD_W-1:0] succ,
                                                 input logic [WORD_W-1:0] far_word);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = (head & HIGH_BIT) | (succ & LOW_BITS);
    v = far_word ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  // output tempering
  function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // seeding recurrence, low 32 bits of the product plus the word index
  function automatic logic [WORD_W-1:0] mt_seed_step(input logic [WORD_W-1:0] prev,
                                                     input logic [WORD_W-1:0] idx);
    logic [WORD_W-1:0] prod;
    prod = SEED_MULT * (prev ^ (prev >> 30));
    return prod + idx;
  endfunction

endpackage

>>> src/mtrr_chain.sv
// mtrr_chain: row of word cells holding the generator state, shifting one place per step
// depends on mtrr_pkg (word width, twist function)

module mtrr_chain import mtrr_pkg::*; #(
  parameter int STATE_WORDS  = STATE_WORDS_DEF,
  parameter int TWIST_OFFSET = TWIST_OFFSET_DEF
) (
  input  logic              clk,
  input  logic              shift,
  input  logic              load_seed,
  input  logic [WORD_W-1:0] seed_word,
  output logic [WORD_W-1:0] twist_word
);

  logic [WORD_W-1:0] cells [STATE_WORDS];
  logic [WORD_W-1:0] tail;

  // new word from the head, its neighbor and the far tap
  assign twist_word = mt_twist(cells[0], cells[1], cells[TWIST_OFFSET]);

  // tail takes a seeding word or the freshly twisted word
  assign tail = load_seed ? seed_word : twist_word;

  // each cell hands its word to the neighbor toward the head
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int j = 0; j < STATE_WORDS - 1; j++) begin
        cells[j] <= cells[j+1];
      end
      cells[STATE_WORDS-1] <= tail;
    end
  end

endmodule

>>> src/mtrr_mod.sv
// mtrr_mod: restoring remainder unit, one quotient bit per cycle over a 32-bit word
// depends on mtrr_pkg (word width, status struct)

module mtrr_mod import mtrr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  input  logic              take,
  output mtrr_div_stat_t    stat,
  output logic [WORD_W-1:0] remainder
);

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dvs;
  logic [WORD_W:0]   partial;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] rem_next;

  // bring down the next dividend bit and try a subtract
  assign partial  = {rem, quo[WORD_W-1]};
  assign diff     = partial - {1'b0, dvs};
  assign rem_next = diff[WORD_W] ? partial[WORD_W-1:0] : diff[WORD_W-1:0];

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
      if (take) begin
        done <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo << 1;
    end
  end

endmodule

>>> src/mersenne_twister_ranged_rng_top.sv
// mersenne_twister_ranged_rng_top: mt19937 generator with a ranged integer output
// depends on mtrr_pkg, mtrr_chain, mtrr_mod
//
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one request beat with range_low and
//   range_high. out channel (out_valid/out_ready/out_data) returns one beat per request
//   with the tempered word and range_low + word mod (range_high - range_low + 1); a span
//   that wraps to zero gives range_low + word.
//   cfg_write_en/cfg_write_data write the seed; the state is then rebuilt.
// Sequence:
//   the twist of one state word happens at accept, then the remainder unit works one
//   bit per cycle; its result is flagged done and enters the output register once
//   that register is free. The next request can be taken only after the result has
//   left the remainder unit, so the bit-serial remainder sets the rate of items.
// Reset and seeding:
//   after reset or a seed write the 624 state cells are filled by the seeding recurrence,
//   one word per cycle, and in_ready stays low until all of them are filled.
// Stall:
//   a held result waits in the output register; a new request may be accepted
//   meanwhile and its result waits in the remainder unit until the register frees.

module mersenne_twister_ranged_rng_top import mtrr_pkg::*; #(
  parameter int STATE_WORDS  = STATE_WORDS_DEF,
  parameter int TWIST_OFFSET = TWIST_OFFSET_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtrr_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mtrr_out_t         out_data,
  input  logic              cfg_write_en,
  input  logic [WORD_W-1:0] cfg_write_data
);

  localparam int CNT_W = $clog2(STATE_WORDS + 1);

  logic [CNT_W-1:0]  seed_cnt;
  logic [WORD_W-1:0] seed_prev;
  logic [WORD_W-1:0] seed_word;
  logic              seeding;
  logic              in_fire;
  logic              shift;
  logic [WORD_W-1:0] twist_word;
  logic [WORD_W-1:0] tempered;
  logic [WORD_W-1:0] span;
  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] low_q;
  logic              span_zero_q;
  mtrr_div_stat_t    div_stat;
  logic [WORD_W-1:0] div_rem;
  logic              div_take;

  // seeding sequencer: first word is the seed, then the recurrence
  assign seeding   = (seed_cnt != CNT_W'(STATE_WORDS));
  assign seed_word = (seed_cnt == '0) ? seed_prev
                                      : mt_seed_step(seed_prev, WORD_W'(seed_cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_cnt  <= '0;
      seed_prev <= SEED_RESET;
    end else if (cfg_write_en) begin
      seed_cnt  <= '0;
      seed_prev <= cfg_write_data;
    end else if (seeding) begin
      seed_cnt  <= seed_cnt + 1'b1;
      seed_prev <= seed_word;
    end
  end

  // request handshake, one item in the remainder unit at a time
  assign in_ready = !seeding && !div_stat.busy && !div_stat.done;
  assign in_fire  = in_valid && in_ready;
  assign shift    = seeding || in_fire;

  mtrr_chain #(
    .STATE_WORDS  (STATE_WORDS),
    .TWIST_OFFSET (TWIST_OFFSET)
  ) u_chain (
    .clk        (clk),
    .shift      (shift),
    .load_seed  (seeding),
    .seed_word  (seed_word),
    .twist_word (twist_word)
  );

  // tempering and span of the accepted request
  assign tempered = mt_temper(twist_word);
  assign span     = in_data.range_high - in_data.range_low + 1'b1;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_q      <= tempered;
      low_q       <= in_data.range_low;
      span_zero_q <= (span == '0);
    end
  end

  mtrr_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (in_fire),
    .dividend  (tempered),
    .divisor   (span),
    .take      (div_take),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  // output register
  assign div_take = div_stat.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      out_data.random_word  <= word_q;
      out_data.ranged_value <= low_q + (span_zero_q ? word_q : div_rem);
    end
  end

  // checks
  a_no_accept_while_seeding: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !seeding)
    else $error("request taken while state is being seeded");

  a_accept_starts_mod: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> div_stat.busy && !in_ready)
    else $error("accepted request did not occupy the remainder unit");

  a_seed_write_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_write_en |=> seeding)
    else $error("seed write did not restart seeding");

  a_seeding_stays_done: assert property (@(posedge clk) disable iff (rst)
    !seeding && !cfg_write_en |=> !seeding)
    else $error("seeding restarted without a seed write");

  a_result_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    div_stat.done && out_valid && !out_ready |=> div_stat.done)
    else $error("pending result lost while output stalled");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// testbench: directed and randomized checks of the mt19937 ranged generator top
// depends on mtrr_pkg and mersenne_twister_ranged_rng_top; keeps its own generator image

module testbench;
  import mtrr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  mtrr_in_t          in_data        = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  mtrr_out_t         out_data;
  logic              cfg_write_en   = 1'b0;
  logic [WORD_W-1:0] cfg_write_data = '0;

  // generator image: state words and read position
  logic [WORD_W-1:0] gen_state [STATE_WORDS_DEF];
  int unsigned       gen_pos;

  mtrr_out_t expected_results [$];
  mtrr_out_t want_beat;

  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;
  int hold_cycles_left = 0;
  int errors           = 0;
  int requests_sent    = 0;
  int results_checked  = 0;
  int seed_writes      = 0;

  mersenne_twister_ranged_rng_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always #6 clk = ~clk;

  // seeding recurrence into the image
  function automatic void reseed_model(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] p;
    gen_state[0] = s;
    for (int i = 1; i < STATE_WORDS_DEF; i++) begin
      p = gen_state[i-1];
      gen_state[i] = SEED_MULT * (p ^ (p >> 30)) + 32'(i);
    end
    gen_pos = STATE_WORDS_DEF;
  endfunction

  // full regeneration of the state words
  function automatic void regenerate_state();
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] v;
    for (int k = 0; k < STATE_WORDS_DEF; k++) begin
      mix = (gen_state[k] & HIGH_BIT) | (gen_state[(k + 1) % STATE_WORDS_DEF] & LOW_BITS);
      v = gen_state[(k + TWIST_OFFSET_DEF) % STATE_WORDS_DEF] ^ (mix >> 1);
      if (mix[0]) begin
        v = v ^ TWIST_MATRIX;
      end
      gen_state[k] = v;
    end
    gen_pos = 0;
  endfunction

  // next tempered word and its ranged value
  function automatic mtrr_out_t predict_draw(input logic [WORD_W-1:0] lo,
                                             input logic [WORD_W-1:0] hi);
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] span;
    mtrr_out_t         r;
    if (gen_pos >= STATE_WORDS_DEF) begin
      regenerate_state();
    end
    w = gen_state[gen_pos];
    gen_pos++;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TEMPER_B);
    w = w ^ ((w << 15) & TEMPER_C);
    w = w ^ (w >> 18);
    span = hi - lo + 32'd1;
    r.random_word = w;
    // a span that wraps to zero adds the raw word
    r.ranged_value = (span == '0) ? lo + w : lo + (w % span);
    return r;
  endfunction

  // receiver: random stalls, or a long hold counted down here
  always @(negedge clk) begin
    if (hold_cycles_left > 0) begin
      out_ready <= 1'b0;
      hold_cycles_left <= hold_cycles_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: word %h ranged %h",
               out_data.random_word, out_data.ranged_value);
        errors++;
      end else begin
        want_beat = expected_results.pop_front();
        results_checked++;
        if (out_data.random_word !== want_beat.random_word) begin
          $error("random_word: expected %h, got %h",
                 want_beat.random_word, out_data.random_word);
          errors++;
        end
        if (out_data.ranged_value !== want_beat.ranged_value) begin
          $error("ranged_value: expected %h, got %h",
                 want_beat.ranged_value, out_data.ranged_value);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // one request beat; called at a falling edge, returns at a falling edge with
  // valid still up so that a following beat can go out without a gap
  task automatic send_request(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_data  <= '{range_low: lo, range_high: hi};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_draw(lo, hi));
    requests_sent++;
    @(negedge clk);
  endtask

  // drop valid and wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // seed write, only while idle
  task automatic write_seed(input logic [WORD_W-1:0] s);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= s;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    reseed_model(s);
    seed_writes++;
  endtask

  // range corners under the reset seed
  task automatic test_range_extremes();
    send_request(32'h0000_0000, 32'hffff_ffff);  // full span
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hffff_ffff, 32'hffff_ffff);
    send_request(32'hffff_ffff, 32'h0000_0000);  // reversed, span of two
    send_request(32'h0000_0001, 32'h0000_0000);  // reversed, span wraps to zero
    send_request(32'h8000_0000, 32'h7fff_ffff);  // span wraps to zero
    send_request(32'h0000_0000, 32'h0000_0001);
    send_request(32'h0000_0000, 32'h7fff_ffff);
    send_request(32'h0000_0000, 32'h8000_0000);
    send_request(32'h0000_0005, 32'h0000_0003);  // reversed range
    send_request(32'h0000_0010, 32'h0000_0020);
    send_request(32'haaaa_aaaa, 32'h5555_5555);
    send_request(32'h5555_5555, 32'haaaa_aaaa);
    send_request(32'h0000_0000, 32'hffff_fffe);
    send_request(32'h0000_0001, 32'hffff_ffff);
  endtask

  // seed register corners and the customary default seed
  task automatic test_seed_extremes();
    logic [WORD_W-1:0] seeds [3] = '{32'h0000_0000, 32'hffff_ffff, 32'd5489};
    foreach (seeds[i]) begin
      wait_drained();
      write_seed(seeds[i]);
      repeat (3) send_request($urandom, $urandom);
    end
  endtask

  // long output hold while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles_left = HOLD_CYCLES;
    @(negedge clk);
    repeat (10) send_request($urandom, $urandom);
  endtask

  // random ranges of several shapes under one idling mix
  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    for (int n = 0; n < count; n++) begin
      lo = $urandom;
      hi = $urandom;
      case ($urandom_range(9))
        5, 6: begin
          hi = lo + $urandom_range(15);
        end
        7: begin
          hi = lo - 32'd1;
        end
        8: begin
          lo = '0;
          hi = '1;
        end
        9: begin
          hi = lo + ((32'd1 << $urandom_range(31)) - 32'd1);
        end
        default: begin
        end
      endcase
      send_request(lo, hi);
    end
  endtask

  initial begin
    reseed_model(SEED_RESET);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_range_extremes();
    test_seed_extremes();
    test_output_backpressure();

    wait_drained();
    write_seed($urandom);
    test_random_traffic(220, 0, 0);
    test_random_traffic(180, 60, 0);
    test_random_traffic(180, 0, 60);
    test_random_traffic(170, 7, 7);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests and %0d checked results over %0d seed writes,",
             requests_sent, results_checked, seed_writes);
    $display("including range corners, seed corners, a long output hold and idle mixes");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
